@@ design/lfu_cache_table_assert.svh @@
// Assertion macros used by the cache table RTL.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lfu_pkg.sv @@
// Types and constants of the LFU cache table.
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 48;
    localparam int CAP_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Summary of one scan over the table
    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  hit_data;
        logic [COUNT_W-1:0] hit_count;
        logic               vic_ok;
        logic [KEY_W-1:0]   vic_key;
        logic [COUNT_W-1:0] vic_count;
        logic [STAMP_W-1:0] vic_stamp;
        logic               free_ok;
    } t_scan_res;

endpackage

@@ design/lfu_cache_table.sv @@
// Top level of the LFU cache table with LRU tie-break.
//
//  channel   direction  tdata (low bit up)                 tuser (low bit up)
//  s_axis    in         lookup_key[31:0], store_value[31:0] func
//  m_axis    out        read_value[31:0], evicted_key[31:0] found, evicted
//  cfg       in         capacity_in_use[4:0] on i_cfg_data  -
//
// After acceptance the sequencer reads every entry over the single read port,
// waits for the last read data, does the update write, if any, and loads the output;
// s_axis_tready is high only in idle, so a new item waits until the last is loaded.
// Reset (synchronous, active low) clears the valid bits, occupancy and stamp
// counter at once; no clearing pass follows. A stalled m_axis holds its beat
// in the output register and the sequencer waits before loading the next one.
module lfu_cache_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // lookup_key, store_value
    input  logic [0:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // read_value, evicted_key
    output logic [1:0]  m_axis_tuser,   // found, evicted
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // capacity_in_use
);

    `include "lfu_cache_table_assert.svh"

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(TABLE_DEPTH);

    lfu_pkg::t_state r_state;
    lfu_pkg::t_state n_state;

    logic [lfu_pkg::CAP_W-1:0]   r_cap;
    logic [OCC_W-1:0]            r_occ;
    logic [lfu_pkg::STAMP_W-1:0] r_stamp;
    logic [TABLE_DEPTH-1:0]      r_valid;
    logic [TABLE_DEPTH-1:0]      n_valid;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_rd_vld;
    logic [IDX_W-1:0]            r_rd_idx;

    logic                        r_func;
    logic [lfu_pkg::KEY_W-1:0]   r_key;
    logic [lfu_pkg::DATA_W-1:0]  r_val;

    logic                        r_found;
    logic [lfu_pkg::DATA_W-1:0]  r_rdval;
    logic                        r_ev;
    logic [lfu_pkg::KEY_W-1:0]   r_evk;

    logic                        r_m_valid;
    logic [63:0]                 r_m_data;
    logic [1:0]                  r_m_user;

    logic w_mem_rd_en;
    logic w_scan_start;
    logic w_upd;
    logic w_resp_load;

    lfu_pkg::t_entry    w_rd_ent;
    lfu_pkg::t_entry    w_wr_ent;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    lfu_pkg::t_scan_res w_scan;
    logic [IDX_W-1:0]   w_hit_idx;
    logic [IDX_W-1:0]   w_vic_idx;
    logic [IDX_W-1:0]   w_free_idx;

    logic [CMP_W-1:0]            w_cap_ext;
    logic [CMP_W-1:0]            w_cap_eff;
    logic                        w_cap_nz;
    logic                        w_full;
    logic                        w_hit_upd;
    logic                        w_ins;
    logic                        w_evict;
    logic                        w_ins_ok;
    logic [IDX_W-1:0]            w_ins_idx;
    logic [lfu_pkg::STAMP_W-1:0] w_stamp_next;
    logic [lfu_pkg::COUNT_W-1:0] w_count_next;

    // Capacity above the table acts as the table depth
    assign w_cap_ext = CMP_W'(r_cap);
    assign w_cap_eff = (w_cap_ext > DEPTH_CMP) ? DEPTH_CMP : w_cap_ext;
    assign w_cap_nz  = (w_cap_eff != '0);
    assign w_full    = (CMP_W'(r_occ) >= w_cap_eff);

    assign w_stamp_next = (r_stamp == lfu_pkg::STAMP_MAX) ? r_stamp : r_stamp + 1'b1;
    assign w_count_next = (w_scan.hit_count == lfu_pkg::COUNT_MAX) ?
                          w_scan.hit_count : w_scan.hit_count + 1'b1;

    assign w_hit_upd = w_scan.hit && w_cap_nz;
    assign w_ins     = !w_scan.hit && (r_func == lfu_pkg::FUNC_PUT) && w_cap_nz;
    assign w_evict   = w_ins && w_full && w_scan.vic_ok;
    assign w_ins_ok  = w_evict || w_scan.free_ok;
    // The evicted slot becomes free, so take it when there is no hole or it lies below the first one
    assign w_ins_idx = (w_evict && (!w_scan.free_ok || (w_vic_idx < w_free_idx))) ?
                       w_vic_idx : w_free_idx;

    // Valid bits after an insert: drop the victim, then mark the new slot
    always_comb begin
        n_valid = r_valid;
        if (w_evict) begin
            n_valid[w_vic_idx] = 1'b0;
        end
        n_valid[w_ins_idx] = 1'b1;
    end

    always_comb begin
        w_wr_en   = w_upd && (w_hit_upd || (w_ins && w_ins_ok));
        w_wr_addr = w_hit_upd ? w_hit_idx : w_ins_idx;
        w_wr_ent.key   = r_key;
        w_wr_ent.stamp = w_stamp_next;
        if (w_hit_upd) begin
            w_wr_ent.data  = (r_func == lfu_pkg::FUNC_PUT) ? r_val : w_scan.hit_data;
            w_wr_ent.count = w_count_next;
        end else begin
            w_wr_ent.data  = r_val;
            w_wr_ent.count = lfu_pkg::COUNT_W'(1);
        end
    end

    // Sequencer: scan every entry, then read-modify-write at most one, then present the result
    always_comb begin
        n_state      = r_state;
        w_mem_rd_en  = 1'b0;
        w_scan_start = 1'b0;
        w_upd        = 1'b0;
        w_resp_load  = 1'b0;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    w_scan_start = 1'b1;
                    n_state      = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                w_mem_rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = lfu_pkg::ST_DRAIN;
                end
            end
            lfu_pkg::ST_DRAIN: begin
                n_state = lfu_pkg::ST_UPDATE;
            end
            lfu_pkg::ST_UPDATE: begin
                w_upd   = 1'b1;
                n_state = lfu_pkg::ST_RESP;
            end
            lfu_pkg::ST_RESP: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_resp_load = 1'b1;
                    n_state     = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state: capacity, scan index, read valid, valid bits, occupancy, stamp counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= lfu_pkg::CAP_RESET;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_occ     <= '0;
            r_stamp   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            r_rd_vld <= w_mem_rd_en;
            if (w_scan_start) begin
                r_idx <= '0;
            end else if (w_mem_rd_en && (r_idx != LAST_IDX)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_upd) begin
                if (w_hit_upd) begin
                    r_stamp <= w_stamp_next;
                end else if (w_ins && w_ins_ok) begin
                    r_stamp <= w_stamp_next;
                    r_valid <= n_valid;
                    if (!w_evict) begin
                        r_occ <= r_occ + 1'b1;
                    end
                end
            end
            if (w_resp_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload: captured item, pending result, output beat
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_scan_start) begin
            r_func <= s_axis_tuser[0];
            r_key  <= s_axis_tdata[31:0];
            r_val  <= s_axis_tdata[63:32];
        end
        if (w_upd) begin
            r_found <= w_hit_upd;
            r_rdval <= (w_hit_upd && (r_func == lfu_pkg::FUNC_GET)) ? w_scan.hit_data : '0;
            r_ev    <= w_evict;
            r_evk   <= w_evict ? w_scan.vic_key : '0;
        end
        if (w_resp_load) begin
            r_m_data <= {r_evk, r_rdval};
            r_m_user <= {r_ev, r_found};
        end
    end

    lfu_mem #(
        .DEPTH(TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_mem_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_ent),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_ent)
    );

    lfu_scan #(
        .DEPTH(TABLE_DEPTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_scan_start),
        .i_rd_vld    (r_rd_vld),
        .i_rd_idx    (r_rd_idx),
        .i_ent_valid (r_valid[r_rd_idx]),
        .i_ent       (w_rd_ent),
        .i_key       (r_key),
        .o_res       (w_scan),
        .o_hit_idx   (w_hit_idx),
        .o_vic_idx   (w_vic_idx),
        .o_free_idx  (w_free_idx)
    );

    assign s_axis_tready = (r_state == lfu_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    `LFU_ASSERT_NOW(a_occ_matches_valid, 1'b1, $countones(r_valid) == int'(r_occ),
        "occupancy disagrees with the valid bits")
    `LFU_ASSERT_NOW(a_slot_for_insert, (r_state == lfu_pkg::ST_UPDATE) && w_ins,
        w_scan.free_ok || w_scan.vic_ok, "new key with neither a free slot nor a victim")
    `LFU_ASSERT_NEXT(a_stamp_moves_on_hit, (r_state == lfu_pkg::ST_UPDATE) && w_hit_upd,
        (r_stamp != $past(r_stamp)) || (r_stamp == lfu_pkg::STAMP_MAX),
        "stamp counter did not advance on a hit")

endmodule

@@ design/lfu_mem.sv @@
// Entry memory: one write port, one read port with registered read data.
module lfu_mem #(
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output lfu_pkg::t_entry                      o_rd_data,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  lfu_pkg::t_entry                      i_wr_data
);

    lfu_pkg::t_entry r_mem [0:DEPTH-1];
    lfu_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/lfu_scan.sv @@
// Scan accumulator: key match, LFU/LRU victim and lowest free slot.
module lfu_scan #(
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic                                       i_rd_vld,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_idx,
    input  logic                                       i_ent_valid,
    input  lfu_pkg::t_entry                            i_ent,
    input  logic [lfu_pkg::KEY_W-1:0]                  i_key,
    output lfu_pkg::t_scan_res                         o_res,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] o_hit_idx,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] o_vic_idx,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] o_free_idx
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lfu_pkg::t_scan_res r_res;
    lfu_pkg::t_scan_res n_res;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [IDX_W-1:0]   n_hit_idx;
    logic [IDX_W-1:0]   r_vic_idx;
    logic [IDX_W-1:0]   n_vic_idx;
    logic [IDX_W-1:0]   r_free_idx;
    logic [IDX_W-1:0]   n_free_idx;
    logic               w_take_vic;

    // Strictly lower count, or same count and older stamp; ties keep the lower index
    assign w_take_vic = !r_res.vic_ok
                     || (i_ent.count < r_res.vic_count)
                     || ((i_ent.count == r_res.vic_count) && (i_ent.stamp < r_res.vic_stamp));

    always_comb begin
        n_res      = r_res;
        n_hit_idx  = r_hit_idx;
        n_vic_idx  = r_vic_idx;
        n_free_idx = r_free_idx;
        if (i_start) begin
            n_res.hit     = 1'b0;
            n_res.vic_ok  = 1'b0;
            n_res.free_ok = 1'b0;
        end else if (i_rd_vld) begin
            if (i_ent_valid) begin
                if (!r_res.hit && (i_ent.key == i_key)) begin
                    n_res.hit       = 1'b1;
                    n_res.hit_data  = i_ent.data;
                    n_res.hit_count = i_ent.count;
                    n_hit_idx       = i_rd_idx;
                end
                if (w_take_vic) begin
                    n_res.vic_ok    = 1'b1;
                    n_res.vic_key   = i_ent.key;
                    n_res.vic_count = i_ent.count;
                    n_res.vic_stamp = i_ent.stamp;
                    n_vic_idx       = i_rd_idx;
                end
            end else if (!r_res.free_ok) begin
                n_res.free_ok = 1'b1;
                n_free_idx    = i_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res      <= '0;
            r_hit_idx  <= '0;
            r_vic_idx  <= '0;
            r_free_idx <= '0;
        end else begin
            r_res      <= n_res;
            r_hit_idx  <= n_hit_idx;
            r_vic_idx  <= n_vic_idx;
            r_free_idx <= n_free_idx;
        end
    end

    assign o_res      = r_res;
    assign o_hit_idx  = r_hit_idx;
    assign o_vic_idx  = r_vic_idx;
    assign o_free_idx = r_free_idx;

endmodule
